### rtl/lcf_pkg.sv
// Package for the LSTM cell forward block: constants, stage types and activation helpers.
package lcf_pkg;

    localparam int FRAC_BITS = 11;
    localparam int SEGMENTS  = 32;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int HALF      = 1 << (FRAC_BITS - 1);
    localparam int STAGES    = 10;

    // table lookup result: segment base, slope step and position within segment
    typedef struct packed {
        logic signed [12:0] base;
        logic [10:0]        diff;
        logic [10:0]        frac;
    } t_lut;

    // activated gates travelling down the pipe with the last flag
    typedef struct packed {
        logic [11:0]        ig;
        logic [11:0]        fg;
        logic [11:0]        og;
        logic signed [12:0] cg;
        logic               last;
    } t_gates;

    // |tanh| at breakpoints 0, 0.5, 1 ... 8, scaled by ONE
    function automatic logic [11:0] tab_mag(input logic [4:0] j);
        case (j)
            5'd0:    return 12'd0;
            5'd1:    return 12'd946;
            5'd2:    return 12'd1560;
            5'd3:    return 12'd1854;
            5'd4:    return 12'd1974;
            5'd5:    return 12'd2021;
            5'd6:    return 12'd2038;
            5'd7:    return 12'd2044;
            5'd8:    return 12'd2047;
            5'd9:    return 12'd2047;
            5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16:
                     return 12'd2048;
            default: return 12'd2048;
        endcase
    endfunction

    // breakpoint k of the table over [-8, 8), odd symmetric about the middle
    function automatic logic signed [12:0] tanh_tab(input logic [5:0] k);
        if (k >= 6'd16)
            return $signed({1'b0, tab_mag(5'(k - 6'd16))});
        else
            return -$signed({1'b0, tab_mag(5'(6'd16 - k))});
    endfunction

    // sigmoid argument read with one extra fraction bit, so x/2 never leaves the table
    function automatic t_lut lut_sig(input logic [15:0] v);
        logic [15:0] u;
        logic [5:0]  k;
        t_lut        r;
        u      = {~v[15], v[14:0]};
        k      = {1'b0, u[15:11]};
        r.base = tanh_tab(k);
        r.diff = 11'(tanh_tab(k + 6'd1) - tanh_tab(k));
        r.frac = u[10:0];
        return r;
    endfunction

    // tanh lookup, saturating outside [-8, 8)
    function automatic t_lut lut_tanh(input logic [15:0] v);
        logic [16:0] u;
        logic [5:0]  k;
        t_lut        r;
        u      = {v[15], v} + 17'd16384;
        k      = {1'b0, u[14:10]};
        r.base = tanh_tab(k);
        r.diff = 11'(tanh_tab(k + 6'd1) - tanh_tab(k));
        r.frac = {u[9:0], 1'b0};
        if (v[15:14] == 2'b10) begin
            r.base = tanh_tab(6'd0);
            r.diff = '0;
            r.frac = '0;
        end else if (v[15:14] == 2'b01) begin
            r.base = tanh_tab(6'(SEGMENTS));
            r.diff = '0;
            r.frac = '0;
        end
        return r;
    endfunction

    // base plus rounded slope term; slope is never negative
    function automatic logic signed [12:0] interp(input logic signed [12:0] base,
                                                  input logic [21:0] prod);
        logic [21:0] q;
        q = (prod + 22'(HALF)) >> FRAC_BITS;
        return base + $signed({2'b00, q[10:0]});
    endfunction

    // (ONE + t + 1) >> 1
    function automatic logic [11:0] sig_fin(input logic signed [12:0] t);
        logic [13:0] s;
        s = 14'(ONE + 1) + {t[12], t};
        return s[12:1];
    endfunction

endpackage

### rtl/lstm_cell_forward.sv
// LSTM cell pointwise forward step: ten-stage pipeline from gate pre-activations to hidden value.
//
// Slave stream: one beat per channel element. tdata carries input, forget and output gate
// pre-activations, candidate pre-activation and previous cell, each signed Q4.11, lowest first;
// tlast marks the final element of a batch and is carried to the output beat.
// Master stream: one beat per element with the three sigmoid gates, the tanh candidate,
// the saturated new cell and the hidden value o*tanh(cell); tlast follows the input.
// Throughput is one element per cycle while the receiver takes beats: every stage is one register
// with its own valid bit, the tanh/sigmoid table is a constant lookup, and each multiply result is
// registered in a stage before it is used.
// Reset clears all valid bits; no beat is presented until one has been accepted.
// When the receiver stalls, the output beat holds and the stages behind it keep filling any
// empty slots; tready on the slave side drops only once all ten stages hold an element.
module lstm_cell_forward (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // input_gate_pre, forget_gate_pre, output_gate_pre, candidate_pre, cell_prev
    input  logic [79:0] i_s_axis_tdata,
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // input_gate, forget_gate, output_gate, candidate, cell_new, hidden_out, 2 zero bits
    output logic [79:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast
);

    localparam int NSTG = lcf_pkg::STAGES;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;

    // stage registers
    lcf_pkg::t_lut       r_s0_lut [4];
    logic signed [15:0]  r_s0_cp;
    logic                r_s0_last;
    logic signed [12:0]  r_s1_base [4];
    logic [21:0]         r_s1_prod [4];
    logic signed [15:0]  r_s1_cp;
    logic                r_s1_last;
    lcf_pkg::t_gates     r_s2_g;
    logic signed [15:0]  r_s2_cp;
    lcf_pkg::t_gates     r_s3_g;
    logic signed [27:0]  r_s3_pf;
    logic signed [25:0]  r_s3_pi;
    lcf_pkg::t_gates     r_s4_g;
    logic signed [15:0]  r_s4_cell;
    lcf_pkg::t_gates     r_s5_g;
    logic signed [15:0]  r_s5_cell;
    lcf_pkg::t_lut       r_s5_lut;
    lcf_pkg::t_gates     r_s6_g;
    logic signed [15:0]  r_s6_cell;
    logic signed [12:0]  r_s6_base;
    logic [21:0]         r_s6_prod;
    lcf_pkg::t_gates     r_s7_g;
    logic signed [15:0]  r_s7_cell;
    logic signed [12:0]  r_s7_tc;
    lcf_pkg::t_gates     r_s8_g;
    logic signed [15:0]  r_s8_cell;
    logic signed [25:0]  r_s8_ph;
    lcf_pkg::t_gates     r_s9_g;
    logic signed [15:0]  r_s9_cell;
    logic signed [12:0]  r_s9_hid;

    // next values
    lcf_pkg::t_lut       n_s0_lut [4];
    logic [21:0]         n_s1_prod [4];
    lcf_pkg::t_gates     n_s2_g;
    logic signed [27:0]  n_s3_pf;
    logic signed [25:0]  n_s3_pi;
    logic signed [15:0]  n_s4_cell;
    logic [21:0]         n_s6_prod;
    logic signed [25:0]  n_s8_ph;
    logic signed [12:0]  n_s9_hid;

    logic signed [28:0]  w_sum;
    logic signed [28:0]  w_rnd;
    logic signed [17:0]  w_q;
    logic signed [25:0]  w_hr;

    // a stage may load when it is empty or its content moves on this cycle
    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || i_m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_s_axis_tready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_s_axis_tvalid;
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_comb begin
        n_s0_lut[0] = lcf_pkg::lut_sig(i_s_axis_tdata[15:0]);
        n_s0_lut[1] = lcf_pkg::lut_sig(i_s_axis_tdata[31:16]);
        n_s0_lut[2] = lcf_pkg::lut_sig(i_s_axis_tdata[47:32]);
        n_s0_lut[3] = lcf_pkg::lut_tanh(i_s_axis_tdata[63:48]);

        for (int i = 0; i < 4; i++) begin
            n_s1_prod[i] = 22'(r_s0_lut[i].diff) * 22'(r_s0_lut[i].frac);
        end

        n_s2_g.ig   = lcf_pkg::sig_fin(lcf_pkg::interp(r_s1_base[0], r_s1_prod[0]));
        n_s2_g.fg   = lcf_pkg::sig_fin(lcf_pkg::interp(r_s1_base[1], r_s1_prod[1]));
        n_s2_g.og   = lcf_pkg::sig_fin(lcf_pkg::interp(r_s1_base[2], r_s1_prod[2]));
        n_s2_g.cg   = lcf_pkg::interp(r_s1_base[3], r_s1_prod[3]);
        n_s2_g.last = r_s1_last;

        n_s3_pf = $signed({1'b0, r_s2_g.fg}) * r_s2_cp;
        n_s3_pi = $signed({1'b0, r_s2_g.ig}) * $signed(r_s2_g.cg);

        // f*c + i*g exact, rounded once, halves away from zero, then saturated
        w_sum = {r_s3_pf[27], r_s3_pf} + {{3{r_s3_pi[25]}}, r_s3_pi};
        w_rnd = w_sum + (w_sum[28] ? 29'(lcf_pkg::HALF - 1) : 29'(lcf_pkg::HALF));
        w_q   = w_rnd[28:11];
        if (w_q[17:15] == 3'b000 || w_q[17:15] == 3'b111)
            n_s4_cell = w_q[15:0];
        else if (w_q[17])
            n_s4_cell = 16'sh8000;
        else
            n_s4_cell = 16'sh7FFF;

        n_s6_prod = 22'(r_s5_lut.diff) * 22'(r_s5_lut.frac);

        n_s8_ph = $signed({1'b0, r_s7_g.og}) * r_s7_tc;

        w_hr     = r_s8_ph + (r_s8_ph[25] ? 26'(lcf_pkg::HALF - 1) : 26'(lcf_pkg::HALF));
        n_s9_hid = w_hr[23:11];
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s0_lut  <= n_s0_lut;
            r_s0_cp   <= i_s_axis_tdata[79:64];
            r_s0_last <= i_s_axis_tlast;
        end
        if (w_en[1]) begin
            for (int i = 0; i < 4; i++) begin
                r_s1_base[i] <= r_s0_lut[i].base;
            end
            r_s1_prod <= n_s1_prod;
            r_s1_cp   <= r_s0_cp;
            r_s1_last <= r_s0_last;
        end
        if (w_en[2]) begin
            r_s2_g  <= n_s2_g;
            r_s2_cp <= r_s1_cp;
        end
        if (w_en[3]) begin
            r_s3_g  <= r_s2_g;
            r_s3_pf <= n_s3_pf;
            r_s3_pi <= n_s3_pi;
        end
        if (w_en[4]) begin
            r_s4_g    <= r_s3_g;
            r_s4_cell <= n_s4_cell;
        end
        if (w_en[5]) begin
            r_s5_g    <= r_s4_g;
            r_s5_cell <= r_s4_cell;
            r_s5_lut  <= lcf_pkg::lut_tanh(r_s4_cell);
        end
        if (w_en[6]) begin
            r_s6_g    <= r_s5_g;
            r_s6_cell <= r_s5_cell;
            r_s6_base <= r_s5_lut.base;
            r_s6_prod <= n_s6_prod;
        end
        if (w_en[7]) begin
            r_s7_g    <= r_s6_g;
            r_s7_cell <= r_s6_cell;
            r_s7_tc   <= lcf_pkg::interp(r_s6_base, r_s6_prod);
        end
        if (w_en[8]) begin
            r_s8_g    <= r_s7_g;
            r_s8_cell <= r_s7_cell;
            r_s8_ph   <= n_s8_ph;
        end
        if (w_en[9]) begin
            r_s9_g    <= r_s8_g;
            r_s9_cell <= r_s8_cell;
            r_s9_hid  <= n_s9_hid;
        end
    end

    assign o_m_axis_tvalid = r_vld[NSTG-1];
    assign o_m_axis_tdata  = {2'b00, r_s9_hid, r_s9_cell, r_s9_g.cg,
                              r_s9_g.og, r_s9_g.fg, r_s9_g.ig};
    assign o_m_axis_tlast  = r_s9_g.last;

`ifndef SYNTH
    a_gate_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_s9_g.ig <= 12'(lcf_pkg::ONE)) && (r_s9_g.fg <= 12'(lcf_pkg::ONE))
                            && (r_s9_g.og <= 12'(lcf_pkg::ONE)))
        else $error("sigmoid gate above one");

    a_hidden_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ($signed(r_s9_hid) >= -13'sd2048) && ($signed(r_s9_hid) <= 13'sd2048)
                            && ($signed(r_s9_g.cg) >= -13'sd2048)
                            && ($signed(r_s9_g.cg) <= 13'sd2048))
        else $error("tanh based output out of range");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> ($countones(r_vld) == NSTG))
        else $error("input stalled with an empty stage");

    a_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && r_vld[NSTG-2]) |=> o_m_axis_tvalid)
        else $error("output beat lost behind a taken beat");
`endif

endmodule
